### src/rcbs_pkg.sv
// Package for the ring closure bond search: widths, codes and control types.
package rcbs_pkg;

  localparam int BOND_SLOTS  = 8192;
  localparam int ATOM_W      = 15;
  localparam int ADDR_W      = (BOND_SLOTS > 1) ? $clog2(BOND_SLOTS) : 1;
  localparam int CNT_W       = $clog2(BOND_SLOTS + 1);
  localparam int MAX_REPORTS = 64;
  localparam int MATCH_SAT   = MAX_REPORTS + 1;
  localparam int MATCH_W     = $clog2(MATCH_SAT + 1);
  localparam int REP_W       = $clog2(MAX_REPORTS + 1);

  typedef logic [ATOM_W-1:0] atom_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_code_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic start_query;
    logic scan_en;
    logic emit_en;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic emit_fire;
    logic emit_last;
  } dp_status_t;

endpackage

### src/rcbs_if.sv
// Handshake interfaces for the input and result channels of the bond search.
interface rcbs_in_if import rcbs_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  atom_t       bond_end_one;
  atom_t       bond_end_two;
  atom_t       chain_a;
  atom_t       chain_b;
  atom_t       chain_c;
  atom_t       chain_d;
  atom_t       chain_e;
  atom_t       chain_f;

  modport source (
    output valid, command, bond_end_one, bond_end_two,
    output chain_a, chain_b, chain_c, chain_d, chain_e, chain_f,
    input  ready
  );
  modport sink (
    input  valid, command, bond_end_one, bond_end_two,
    input  chain_a, chain_b, chain_c, chain_d, chain_e, chain_f,
    output ready
  );
endinterface

interface rcbs_out_if import rcbs_pkg::*; ();
  logic  valid;
  logic  ready;
  atom_t ring_a;
  atom_t ring_b;
  atom_t ring_c;
  atom_t ring_d;
  atom_t ring_e;
  atom_t ring_f;
  atom_t closing_atom;
  logic  found;
  logic  overflow;
  logic  last;

  modport source (
    output valid, ring_a, ring_b, ring_c, ring_d, ring_e, ring_f,
    output closing_atom, found, overflow, last,
    input  ready
  );
  modport sink (
    input  valid, ring_a, ring_b, ring_c, ring_d, ring_e, ring_f,
    input  closing_atom, found, overflow, last,
    output ready
  );
endinterface

### src/rcbs_ctrl.sv
// Controller state machine of the bond search: idle, table scan, report emission.
module rcbs_ctrl import rcbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   in_fire;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_command == CMD_QUERY)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.scan_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.emit_fire && status.emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    cmd.scan_en     = 1'b0;
    cmd.emit_en     = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready    = 1'b1;
      S_SCAN:  cmd.scan_en = 1'b1;
      S_EMIT:  cmd.emit_en = 1'b1;
      default: in_ready    = 1'b0;
    endcase
    cmd.accept      = in_fire;
    cmd.start_query = in_fire && (in_command == CMD_QUERY);
  end

`ifndef SYNTHESIS
  a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && !status.scan_done) |=> (state_r == S_SCAN))
    else $error("scan left before the table was done");
`endif

endmodule

### src/rcbs_dp.sv
// Datapath of the bond search: bond memory, scan counters, match count, result register.
module rcbs_dp import rcbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  logic [1:0]  in_command,
  input  atom_t       in_bond_end_one,
  input  atom_t       in_bond_end_two,
  input  atom_t       in_chain_a,
  input  atom_t       in_chain_b,
  input  atom_t       in_chain_c,
  input  atom_t       in_chain_d,
  input  atom_t       in_chain_e,
  input  atom_t       in_chain_f,
  rcbs_out_if.source  out_ch
);

  logic [2*ATOM_W-1:0] mem [BOND_SLOTS];
  logic [2*ATOM_W-1:0] rdata_r;

  logic [CNT_W-1:0]   bond_count_r;
  logic [CNT_W-1:0]   rd_idx_r;
  logic               rd_vld_r;
  logic [MATCH_W-1:0] match_cnt_r;
  logic [MATCH_W-1:0] match_cnt_nxt;
  logic [REP_W-1:0]   emitted_r;
  logic               chain_ok_r;
  atom_t              ch_a_r, ch_b_r, ch_c_r, ch_d_r, ch_e_r, ch_f_r;

  logic               out_valid_r;
  logic               out_found_r;
  logic               out_ovf_r;
  logic               out_last_r;
  atom_t              out_closing_r;
  atom_t              out_ring_a_r, out_ring_b_r, out_ring_c_r;
  atom_t              out_ring_d_r, out_ring_e_r, out_ring_f_r;

  atom_t              end_one;
  atom_t              end_two;
  logic               hit_one;
  logic               hit_two;
  logic [MATCH_W:0]   match_sum;
  logic               saturated;
  logic               table_full;
  logic               do_load;
  logic               issue;
  logic [REP_W-1:0]   rep_total;
  logic               emit_fire;
  logic               emit_last;

  assign end_one    = rdata_r[ATOM_W-1:0];
  assign end_two    = rdata_r[2*ATOM_W-1:ATOM_W];
  assign hit_one    = (end_one == ch_f_r) && (end_two == ch_a_r);
  assign hit_two    = (end_two == ch_f_r) && (end_one == ch_a_r);
  assign saturated  = (match_cnt_r == MATCH_W'(MATCH_SAT));
  assign table_full = (bond_count_r == CNT_W'(BOND_SLOTS));
  assign do_load    = cmd.accept && (in_command == CMD_LOAD) && !table_full;
  assign issue      = cmd.scan_en && (rd_idx_r < bond_count_r);

  always_comb begin
    match_sum = {1'b0, match_cnt_r} + (MATCH_W+1)'(hit_one) + (MATCH_W+1)'(hit_two);
    if (match_sum > (MATCH_W+1)'(MATCH_SAT)) begin
      match_cnt_nxt = MATCH_W'(MATCH_SAT);
    end else begin
      match_cnt_nxt = match_sum[MATCH_W-1:0];
    end
  end

  // Number of results this query gives: one "not found" word when nothing matched.
  always_comb begin
    if (match_cnt_r == '0) begin
      rep_total = REP_W'(1);
    end else if (match_cnt_r > MATCH_W'(MAX_REPORTS)) begin
      rep_total = REP_W'(MAX_REPORTS);
    end else begin
      rep_total = REP_W'(match_cnt_r);
    end
  end

  assign emit_fire = cmd.emit_en && (!out_valid_r || out_ch.ready);
  assign emit_last = (REP_W'(emitted_r + REP_W'(1)) == rep_total);

  assign status.scan_done = saturated || !chain_ok_r ||
                            (!rd_vld_r && (rd_idx_r == bond_count_r));
  assign status.emit_fire = emit_fire;
  assign status.emit_last = emit_last;

  always_ff @(posedge clk) begin
    if (do_load) begin
      mem[bond_count_r[ADDR_W-1:0]] <= {in_bond_end_two, in_bond_end_one};
    end
    rdata_r <= mem[rd_idx_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bond_count_r <= '0;
    end else if (cmd.accept && (in_command == CMD_CLEAR)) begin
      bond_count_r <= '0;
    end else if (do_load) begin
      bond_count_r <= bond_count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      rd_vld_r    <= 1'b0;
      match_cnt_r <= '0;
      emitted_r   <= '0;
      chain_ok_r  <= 1'b0;
    end else if (cmd.start_query) begin
      rd_idx_r    <= '0;
      rd_vld_r    <= 1'b0;
      match_cnt_r <= '0;
      emitted_r   <= '0;
      chain_ok_r  <= (in_chain_a != in_chain_b) && (in_chain_a != in_chain_c) &&
                     (in_chain_a != in_chain_d) && (in_chain_a != in_chain_e);
    end else begin
      if (issue) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
      end
      rd_vld_r <= issue;
      if (cmd.scan_en && rd_vld_r && chain_ok_r && !saturated) begin
        match_cnt_r <= match_cnt_nxt;
      end
      if (emit_fire) begin
        emitted_r <= emitted_r + REP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      ch_a_r <= in_chain_a;
      ch_b_r <= in_chain_b;
      ch_c_r <= in_chain_c;
      ch_d_r <= in_chain_d;
      ch_e_r <= in_chain_e;
      ch_f_r <= in_chain_f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Every matching report carries the same chain; the closing atom is always a.
  // The chain is copied into the result register so that a waiting word keeps
  // its chain when the next query is accepted.
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_ring_a_r  <= ch_a_r;
      out_ring_b_r  <= ch_b_r;
      out_ring_c_r  <= ch_c_r;
      out_ring_d_r  <= ch_d_r;
      out_ring_e_r  <= ch_e_r;
      out_ring_f_r  <= ch_f_r;
      out_found_r   <= (match_cnt_r != '0);
      out_closing_r <= (match_cnt_r != '0) ? ch_a_r : '0;
      out_last_r    <= emit_last;
      out_ovf_r     <= emit_last && (match_cnt_r > MATCH_W'(MAX_REPORTS));
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.ring_a       = out_ring_a_r;
  assign out_ch.ring_b       = out_ring_b_r;
  assign out_ch.ring_c       = out_ring_c_r;
  assign out_ch.ring_d       = out_ring_d_r;
  assign out_ch.ring_e       = out_ring_e_r;
  assign out_ch.ring_f       = out_ring_f_r;
  assign out_ch.closing_atom = out_closing_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.overflow     = out_ovf_r;
  assign out_ch.last         = out_last_r;

`ifndef SYNTHESIS
  a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
    match_cnt_r <= MATCH_W'(MATCH_SAT))
    else $error("match count ran past its saturation value");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bond_count_r <= CNT_W'(BOND_SLOTS))
    else $error("bond count exceeds the table size");
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |-> (emitted_r < rep_total))
    else $error("more results emitted than the query owns");
  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> (rd_idx_r <= bond_count_r))
    else $error("scan read past the stored bonds");
`endif

endmodule

### src/ring_closure_bond_search.sv
// Top level of the ring closure bond search: controller plus datapath.
//
// The block holds a table of up to BOND_SLOTS bonds, each a pair of 15-bit
// atom ids. Words arrive on in_ch with valid/ready. A clear word empties the
// table and a load word appends one bond; neither gives a result. A load
// into a full table is dropped, and command 3 is ignored. A query word
// carries a six-atom chain a..f. The block then reads the stored bonds one
// per cycle from its bond memory, oldest first, and counts bonds that join
// f to a (a bond of f to f with a equal to f counts twice). The scan stops
// early once more than 64 matches are seen, and at once when a equals any
// of b..e. After the scan the block emits one result word per match, up to
// 64 words; out_ch gives one word with found=0 when nothing matched, and
// overflow on the last word when matches were dropped. While a query runs,
// in_ch.ready stays low. Results leave through an output register: when the
// receiver stalls, the block holds its word and waits, and it accepts the next
// input word as soon as the last result of a query sits in that register.
// Reset (rst_n low, synchronous) empties the table and drops any query in
// progress.
module ring_closure_bond_search import rcbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rcbs_in_if.sink   in_ch,
  rcbs_out_if.source out_ch
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  // The controller sequences idle, scan and emit phases.
  rcbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // The datapath owns the bond memory, the match counter and the result register.
  rcbs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_command      (in_ch.command),
    .in_bond_end_one (in_ch.bond_end_one),
    .in_bond_end_two (in_ch.bond_end_two),
    .in_chain_a      (in_ch.chain_a),
    .in_chain_b      (in_ch.chain_b),
    .in_chain_c      (in_ch.chain_c),
    .in_chain_d      (in_ch.chain_d),
    .in_chain_e      (in_ch.chain_e),
    .in_chain_f      (in_ch.chain_f),
    .out_ch          (out_ch)
  );

endmodule
